/* hdl/heading_pid_thrust_mixer_top_assert.svh */
// Assertion macros for the heading PID thrust mixer
`ifndef HEADING_PID_THRUST_MIXER_TOP_ASSERT_SVH
`define HEADING_PID_THRUST_MIXER_TOP_ASSERT_SVH
`ifndef SYNTH
`define HPM_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define HPM_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define HPM_ASSERT_IMP(label, clk, rst_n, a, c)
`define HPM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* hdl/hpm_pkg.sv */
package hpm_pkg;
	localparam int ErrW  = 19;
	localparam int WErrW = 18;
	localparam int DistW = 24;
	localparam int TimeW = 32;
	localparam int GainW = 16;
	localparam int OutW  = 17;
	localparam int IntW  = 48;
	localparam int QDepth = 2;
	localparam logic signed [ErrW-1:0] Deg180 = 19'sd46080;
	localparam logic signed [ErrW-1:0] Deg360 = 19'sd92160;
	localparam logic signed [ErrW-1:0] Deg540 = 19'sd138240;
	localparam logic [1:0] CfgGainP = 2'd0;
	localparam logic [1:0] CfgGainI = 2'd1;
	localparam logic [1:0] CfgGainD = 2'd2;

	// Classified item handed from front to back
	typedef struct packed {
		logic                    func;
		logic                    restart;
		logic signed [WErrW-1:0] err;
		logic [DistW-1:0]        distance;
		logic [TimeW-1:0]        stamp;
	} hpm_item_t;
endpackage

/* hdl/hpm_front.sv */
module hpm_front import hpm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic signed [ErrW-1:0] heading_error,
	input  logic [DistW-1:0]       distance,
	input  logic [TimeW-1:0]       timestamp,
	output logic                   q_valid,
	input  logic                   q_pop,
	output hpm_item_t              q_item
);
	hpm_item_t               mem_q [QDepth];
	logic                    wp_q, rp_q;
	logic [1:0]              cnt_q;
	logic [1:0]              last_mode_q;
	logic signed [ErrW-1:0]  ec, ew;
	hpm_item_t               it;
	logic                    push;

	assign in_stall = (cnt_q == 2'(QDepth));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	always_comb begin
		// clamp to +-540 then wrap once
		if (heading_error < -Deg540) ec = -Deg540;
		else if (heading_error > Deg540) ec = Deg540;
		else ec = heading_error;
		if (ec < -Deg180) ew = ec + Deg360;
		else if (ec > Deg180) ew = ec - Deg360;
		else ew = ec;
		it.func     = func;
		it.restart  = ({1'b0, func} != last_mode_q);
		it.err      = WErrW'(ew);
		it.distance = distance;
		it.stamp    = timestamp;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
			last_mode_q <= 2'd2;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
				last_mode_q <= {1'b0, func};
			end
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	`include "heading_pid_thrust_mixer_top_assert.svh"
	`HPM_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_pop, q_valid)
	`HPM_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(QDepth))
	`HPM_ASSERT_NXT(a_full_stall, clk, arst_n, push && !q_pop && cnt_q == 2'd1, in_stall)
endmodule

/* hdl/hpm_div.sv */
// Restoring unsigned divider, one quotient bit per cycle
module hpm_div import hpm_pkg::*; #(
	parameter int NW = 64,
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] c_q;
	logic          busy_q;
	logic [DW:0]   sh, sub;

	assign sh   = {r_q[DW-1:0], n_q[NW-1]};
	assign sub  = sh - {1'b0, d_q};
	assign quo  = n_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], !sub[DW]};
			r_q <= sub[DW] ? sh : sub;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			c_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				c_q <= CW'(NW);
			end else if (busy_q) begin
				c_q <= c_q - 1'b1;
				if (c_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

/* hdl/hpm_back.sv */
module hpm_back import hpm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic signed [GainW-1:0] kp,
	input  logic signed [GainW-1:0] ki,
	input  logic signed [GainW-1:0] kd,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  hpm_item_t              q_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [OutW-1:0] thrust_right,
	output logic signed [OutW-1:0] thrust_left,
	output logic                   saturated
);
	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_INT, S_PM, S_DM, S_DDIV, S_DWAIT,
		S_IM, S_IDIV, S_IWAIT, S_MIX, S_OUT
	} st_t;
	st_t st_q;

	// reciprocal of 125 for one byte digit: v < 32000 keeps it exact
	localparam logic [15:0] IRecip = 16'd33555;

	hpm_item_t              it_q;
	logic [TimeW-1:0]       last_time_q;
	logic signed [WErrW-1:0] last_err_q;
	logic signed [IntW-1:0] integ_q;
	logic [TimeW-1:0]       dt_q;
	logic signed [50:0]     edt_q;
	logic signed [49:0]     isum;
	logic                   sat_q;
	logic signed [47:0]     thr_q;
	logic signed [34:0]     dnum_q;
	logic signed [40:0]     spd_q;
	logic                   neg_q;

	logic                   dv_start, dv_done;
	logic [63:0]            dv_num, dv_quo;
	logic [47:0]            dv_den;
	logic [63:0]            dv_num_q;
	logic [47:0]            dv_den_q;

	// 16x48 product for the integral term
	logic signed [IntW+16:0] mi_q;

	// integral scaling: divide by 125 one byte digit per cycle
	logic [55:0]            ix_q, iq_q;
	logic [6:0]             ir_q;
	logic [2:0]             ic_q;
	logic [14:0]            iv;
	logic [29:0]            iprod;
	logic [7:0]             iqd;
	logic [6:0]             irem;

	assign dv_num = dv_num_q;
	assign dv_den = dv_den_q;

	assign iv    = {ir_q, ix_q[55:48]};
	assign iprod = 30'(iv) * 30'(IRecip);
	assign iqd   = iprod[29:22];
	assign irem  = 7'(iv - 15'(iqd) * 15'd125);

	hpm_div #(.NW(64), .DW(48)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo)
	);

	function automatic logic signed [OutW-1:0] sat17(input logic signed [48:0] v,
		output logic hit);
		hit = 1'b0;
		if (v > 49'sd65535) begin sat17 = 17'sd65535; hit = 1'b1; end
		else if (v < -49'sd65536) begin sat17 = -17'sd65536; hit = 1'b1; end
		else sat17 = OutW'(v);
	endfunction

	assign isum = 50'(integ_q) + 50'(edt_q);
	assign q_pop = (st_q == S_IDLE) && q_valid;

	logic signed [63:0] pprod;
	logic signed [48:0] rv, lv;
	logic               hr, hl;
	logic signed [OutW-1:0] rs, ls;

	always_comb begin
		pprod = 64'(kp) * 64'(it_q.err);
		if (it_q.func) begin
			rv = 49'(spd_q) - 49'(thr_q);
			lv = 49'(spd_q) + 49'(thr_q);
		end else begin
			rv = -49'(thr_q);
			lv = 49'(thr_q);
		end
		rs = sat17(rv, hr);
		ls = sat17(lv, hl);
	end

	always_ff @(posedge clk) begin
		dv_start <= 1'b0;
		unique case (st_q)
			S_IDLE: if (q_valid) begin
				it_q <= q_item;
			end
			S_MUL1: begin
				dt_q <= it_q.stamp - (it_q.restart ? it_q.stamp : last_time_q);
				if (it_q.restart) begin
					integ_q <= '0;
					last_err_q <= '0;
				end
				sat_q <= 1'b0;
			end
			S_MUL2: edt_q <= 51'(it_q.err) * 51'($signed({1'b0, dt_q}));
			S_INT: begin
				if (isum > 50'(49'sh7FFF_FFFF_FFFF)) begin
					integ_q <= 48'sh7FFF_FFFF_FFFF; sat_q <= 1'b1;
				end else if (isum < -50'sh8000_0000_0000) begin
					integ_q <= -48'sh8000_0000_0000; sat_q <= 1'b1;
				end else integ_q <= IntW'(isum);
				dnum_q <= 35'(kd) * 35'(it_q.err - last_err_q);
			end
			S_PM: begin
				// P term: round half away by 256
				thr_q <= (pprod < 0) ? -48'((-pprod + 64'sd128) >>> 8)
					: 48'((pprod + 64'sd128) >>> 8);
				spd_q <= 41'((64'(kp) * 64'($signed({1'b0, it_q.distance})) + 64'sd128) >>> 8);
			end
			S_DM: begin
				if (spd_q < 41'sd2560) spd_q <= 41'sd2560;
				else if (spd_q > 41'sd25600) spd_q <= 41'sd25600;
				if (spd_q < 0 && 64'(kp) * 64'($signed({1'b0, it_q.distance})) < 0)
					spd_q <= 41'sd2560;
				neg_q <= dnum_q < 0;
				dv_num_q <= 64'((dnum_q < 0 ? -dnum_q : dnum_q)) * 64'd1000 * 64'd2
					+ 64'({dt_q, 8'd0}) ;
				dv_den_q <= 48'({dt_q, 8'd0}) << 1;
			end
			S_DDIV: dv_start <= (dt_q != '0);
			S_DWAIT: if (dv_done) begin
				thr_q <= thr_q + (neg_q ? -48'(dv_quo) : 48'(dv_quo));
			end
			S_IM: begin
				mi_q <= 65'(ki) * 65'(integ_q);
			end
			S_IDIV: begin
				// round, drop the factor 2^11 of 256000, leave 125 to the digit loop
				neg_q <= mi_q < 0;
				ix_q <= 56'((64'(mi_q < 0 ? -mi_q : mi_q) + 64'd128000) >> 11);
				ir_q <= '0;
				iq_q <= '0;
				ic_q <= 3'd7;
			end
			S_IWAIT: if (ic_q != 3'd0) begin
				ix_q <= {ix_q[47:0], 8'd0};
				iq_q <= {iq_q[47:0], iqd};
				ir_q <= irem;
				ic_q <= ic_q - 3'd1;
			end else begin
				thr_q <= thr_q + (neg_q ? -48'(iq_q) : 48'(iq_q));
			end
			S_MIX: begin
				thrust_right <= rs;
				thrust_left  <= ls;
				saturated    <= sat_q | hr | hl;
				last_err_q   <= it_q.err;
				last_time_q  <= it_q.stamp;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE:  if (q_valid) st_q <= S_MUL1;
				S_MUL1:  st_q <= S_MUL2;
				S_MUL2:  st_q <= S_INT;
				S_INT:   st_q <= S_PM;
				S_PM:    st_q <= S_DM;
				S_DM:    st_q <= S_DDIV;
				S_DDIV:  st_q <= (dt_q != '0) ? S_DWAIT : S_IM;
				S_DWAIT: if (dv_done) st_q <= S_IM;
				S_IM:    st_q <= S_IDIV;
				S_IDIV:  st_q <= S_IWAIT;
				S_IWAIT: if (ic_q == 3'd0) st_q <= S_MIX;
				S_MIX: begin
					st_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`include "heading_pid_thrust_mixer_top_assert.svh"
	`HPM_ASSERT_IMP(a_valid_out, clk, arst_n, out_valid, st_q == S_OUT)
	`HPM_ASSERT_IMP(a_pop_idle, clk, arst_n, q_pop, st_q == S_IDLE)
	`HPM_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(thrust_left))
endmodule

/* hdl/heading_pid_thrust_mixer_top.sv */
// Heading PID thrust mixer. Each beat on the input channel yields exactly one
// beat of thruster commands. A front stage clamps and wraps the heading error
// and flags a mode change, then parks the item in a two-entry queue; a back
// sequencer runs the PID arithmetic with a restoring divider for the
// derivative term and a byte-wise constant division for the integral term.
// The divider is skipped when the elapsed time is zero; a stalled result beat
// holds the sequencer until it is taken, and the input stalls while the
// queue is full. The user must write gains through the cfg port only while the
// block is idle; the block itself does not enforce this.
module heading_pid_thrust_mixer_top import hpm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [GainW-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  logic signed [ErrW-1:0]  heading_error,
	input  logic [DistW-1:0]        distance,
	input  logic [TimeW-1:0]        timestamp,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OutW-1:0]  thrust_right,
	output logic signed [OutW-1:0]  thrust_left,
	output logic                    saturated
);
	logic signed [GainW-1:0] kp_q, ki_q, kd_q;
	logic      qv, qp;
	hpm_item_t qi;

	// hold gain registers; ignore writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0; ki_q <= '0; kd_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgGainP: kp_q <= cfg_data;
				CfgGainI: ki_q <= cfg_data;
				CfgGainD: kd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hpm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(func), .heading_error(heading_error), .distance(distance),
		.timestamp(timestamp), .q_valid(qv), .q_pop(qp), .q_item(qi)
	);

	hpm_back u_back (
		.clk(clk), .arst_n(arst_n), .kp(kp_q), .ki(ki_q), .kd(kd_q),
		.q_valid(qv), .q_pop(qp), .q_item(qi), .out_valid(out_valid),
		.out_stall(out_stall), .thrust_right(thrust_right),
		.thrust_left(thrust_left), .saturated(saturated)
	);
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import hpm_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [GainW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic func;
	logic signed [ErrW-1:0] heading_error;
	logic [DistW-1:0] distance;
	logic [TimeW-1:0] timestamp;
	logic out_valid;
	logic out_stall;
	logic signed [OutW-1:0] thrust_right;
	logic signed [OutW-1:0] thrust_left;
	logic saturated;

	heading_pid_thrust_mixer_top u_top (.*);

	// one expected thruster command
	typedef struct {
		logic signed [OutW-1:0] right;
		logic signed [OutW-1:0] left;
		logic                   sat;
	} thrust_cmd_t;

	thrust_cmd_t thrust_q[$];

	// controller state mirrored from the block
	longint kp, ki, kd;
	logic [1:0] prev_mode;
	logic [31:0] prev_stamp;
	longint prev_err;
	longint err_sum;

	int errors;
	longint cycle_cnt;
	bit quiet;        // no random idling on either side
	bit hold_off;     // receiver holds off for a long stretch
	int hold_cycles;

	localparam longint SumMax = 64'sh7FFF_FFFF_FFFF;
	localparam longint SumMin = -SumMax - 1;
	localparam longint CycleLimit = 64'd3_000_000;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// round to nearest, halves away from zero
	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint limit(longint v, longint lo, longint hi, ref bit hit);
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		return v;
	endfunction

	function automatic thrust_cmd_t mix_thrust(logic m, logic signed [ErrW-1:0] herr,
			logic [DistW-1:0] distv, logic [TimeW-1:0] now);
		thrust_cmd_t r;
		bit sat;
		bit dummy;
		longint e, dt, thrust, right, left, speed;
		sat = 0;
		dummy = 0;
		if ({1'b0, m} != prev_mode) begin
			prev_stamp = now;
			prev_err = 0;
			err_sum = 0;
			prev_mode = {1'b0, m};
		end
		e = limit(longint'(herr), -longint'(Deg540), longint'(Deg540), dummy);
		if (e < -longint'(Deg180)) e += longint'(Deg360);
		else if (e > longint'(Deg180)) e -= longint'(Deg360);
		dt = longint'(32'(now - prev_stamp));
		err_sum = limit(err_sum + e * dt, SumMin, SumMax, sat);
		thrust = round_div(kp * e, 256);
		if (dt != 0)
			thrust += round_div(kd * (e - prev_err) * 1000, dt * 256);
		thrust += round_div(ki * err_sum, 256000);
		if (!m) begin
			right = -thrust;
			left = thrust;
		end else begin
			speed = limit(round_div(kp * longint'(distv), 256), 2560, 25600, dummy);
			right = speed - thrust;
			left = speed + thrust;
		end
		r.right = OutW'(limit(right, -65536, 65535, sat));
		r.left = OutW'(limit(left, -65536, 65535, sat));
		r.sat = sat;
		prev_err = e;
		prev_stamp = now;
		return r;
	endfunction

	// receiver stall: random, quiet or a long hold-off
	always @(negedge clk) begin
		if (hold_off && hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 11);
		end
	end

	// check each result beat against the oldest expected command
	always @(posedge clk) begin
		thrust_cmd_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (thrust_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				x = thrust_q.pop_front();
				if (thrust_right !== x.right) begin
					$error("thrust_right exp %0d got %0d", x.right, thrust_right);
					errors++;
				end
				if (thrust_left !== x.left) begin
					$error("thrust_left exp %0d got %0d", x.left, thrust_left);
					errors++;
				end
				if (saturated !== x.sat) begin
					$error("saturated exp %0d got %0d", x.sat, saturated);
					errors++;
				end
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// send one input beat, predicting its command on acceptance
	task automatic send_beat(logic m, logic signed [ErrW-1:0] herr,
			logic [DistW-1:0] distv, logic [TimeW-1:0] now);
		while (!quiet && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= m;
		heading_error <= herr;
		distance <= distv;
		timestamp <= now;
		// stall only moves at the rising edge: hold until it is low here
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		thrust_q.push_back(mix_thrust(m, herr, distv, now));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (thrust_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_gain(logic [1:0] idx, logic signed [GainW-1:0] g);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= g;
		@(negedge clk);
		case (idx)
			CfgGainP: kp = longint'(g);
			CfgGainI: ki = longint'(g);
			default:  kd = longint'(g);
		endcase
	endtask

	task automatic set_gains(logic signed [GainW-1:0] p, logic signed [GainW-1:0] i,
			logic signed [GainW-1:0] d);
		drain();
		write_gain(CfgGainP, p);
		write_gain(CfgGainI, i);
		write_gain(CfgGainD, d);
		cfg_we <= 1'b0;
	endtask

	// random beat: mostly small time steps, sometimes wild values
	logic [31:0] clock_ms;
	task automatic random_beat(int mode_flip_pct);
		logic m;
		logic signed [ErrW-1:0] herr;
		logic [DistW-1:0] distv;
		m = ($urandom_range(99) < mode_flip_pct) ? ~func : func;
		if ($urandom_range(9) == 0) herr = ErrW'($urandom);
		else herr = ErrW'($signed($urandom_range(276480)) - 138240);
		distv = ($urandom_range(3) == 0) ? DistW'($urandom) : DistW'($urandom_range(40000));
		case ($urandom_range(9))
			0: clock_ms = $urandom;
			1: clock_ms = clock_ms;
			2: clock_ms = clock_ms + $urandom_range(100000);
			default: clock_ms = clock_ms + $urandom_range(1, 200);
		endcase
		send_beat(m, herr, distv, clock_ms);
	endtask

	task automatic test_directed();
		set_gains(16'sh0100, 16'sh0080, 16'sh0040);
		send_beat(1'b0, 19'sd0, 24'd0, 32'd0);
		send_beat(1'b0, 19'sd46080, 24'd0, 32'd10);
		send_beat(1'b0, -19'sd46080, 24'd0, 32'd20);
		send_beat(1'b0, 19'sd46081, 24'd0, 32'd30);
		send_beat(1'b0, 19'sd138240, 24'd0, 32'd40);
		send_beat(1'b0, -19'sd138240, 24'd0, 32'd50);
		send_beat(1'b0, 19'sh3FFFF, 24'd0, 32'd60);   // beyond range, clamped
		send_beat(1'b0, 19'sh40000, 24'd0, 32'd70);
		send_beat(1'b0, 19'sd1000, 24'd0, 32'd70);     // zero elapsed time
		send_beat(1'b1, 19'sd500, 24'hFFFFFF, 32'd80); // mode change
		send_beat(1'b1, -19'sd500, 24'd0, 32'd90);
		send_beat(1'b1, 19'sd200, 24'd2560, 32'd5);   // time goes backwards
		send_beat(1'b0, 19'sd0, 24'd0, 32'hFFFFFFFF);
		send_beat(1'b0, 19'sd46080, 24'd0, 32'd0);
		set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_beat(1'b0, 19'sd46080, 24'd0, 32'd0);
		send_beat(1'b0, 19'sd46080, 24'd0, 32'hFFFFFFFF); // integral overflow
		send_beat(1'b0, 19'sd46080, 24'd0, 32'hFFFFFFF0);
		send_beat(1'b1, -19'sd46080, 24'hFFFFFF, 32'd1);
		set_gains(16'sh8000, 16'sh8000, 16'sh8000);
		send_beat(1'b1, 19'sd46080, 24'hFFFFFF, 32'd2);
		send_beat(1'b1, -19'sd46080, 24'h000001, 32'd3);
		send_beat(1'b0, 19'sd12345, 24'd0, 32'hFFFFFFFF);
		send_beat(1'b0, -19'sd12345, 24'd0, 32'd0);
	endtask

	task automatic test_random_gains();
		for (int ph = 0; ph < 8; ph++) begin
			set_gains(GainW'($urandom), GainW'($urandom), GainW'($urandom));
			quiet = (ph == 3);
			for (int n = 0; n < 110; n++)
				random_beat(5);
		end
		quiet = 0;
	endtask

	// fill the block while the receiver holds off
	task automatic test_backpressure();
		set_gains(16'sh0200, -16'sh0010, 16'sh0100);
		hold_cycles = 3000;
		hold_off = 1;
		for (int n = 0; n < 40; n++)
			random_beat(10);
		hold_off = 0;
	endtask

	initial begin
		errors = 0;
		cycle_cnt = 0;
		quiet = 0;
		hold_off = 0;
		hold_cycles = 0;
		clock_ms = 0;
		kp = 0;
		ki = 0;
		kd = 0;
		prev_mode = 2'd2;
		prev_stamp = '0;
		prev_err = 0;
		err_sum = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		func = 1'b0;
		heading_error = '0;
		distance = '0;
		timestamp = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random_gains();
		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* files.f */
+incdir+hdl
hdl/hpm_pkg.sv
hdl/hpm_front.sv
hdl/hpm_div.sv
hdl/hpm_back.sv
hdl/heading_pid_thrust_mixer_top.sv
sim/tb_top.sv
